### sv/tccu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccu_pkg
// shared constants, types and the arctangent table of the compass heading unit
// ----------------------------------------------------------------------------
package tccu_pkg;

  localparam int unsigned TABLE_LEN    = 24;
  localparam int unsigned CORDIC_STEPS = 16;

  // 1/K in Q30, start value of the rotation cordic
  localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] TURN_QUARTER = 34'sd1073741824;
  localparam logic signed [33:0] TURN_HALF    = 34'sd2147483648;

  // register indexes
  localparam logic [2:0] REG_OFFSET_X    = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y    = 3'd1;
  localparam logic [2:0] REG_OFFSET_Z    = 3'd2;
  localparam logic [2:0] REG_TILT_ENABLE = 3'd3;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } cal_t;

  // atan(2^-i) in turn units, 2^32 = 2pi
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  // subtract offset and clamp to signed 16 bits
  function automatic logic signed [15:0] sub_sat16(input logic signed [15:0] a,
                                                   input logic signed [15:0] b);
    logic signed [16:0] d;
    d = 17'(a) - 17'(b);
    if (d > 17'sd32767) begin
      return 16'sh7fff;
    end else if (d < -17'sd32768) begin
      return 16'sh8000;
    end
    return d[15:0];
  endfunction

endpackage
`default_nettype wire

### sv/tccu_sincos.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccu_sincos
// pipelined rotation cordic, cos and sin in Q30 of a half-turn angle
// ----------------------------------------------------------------------------
module tccu_sincos #(
  parameter int unsigned STEPS = tccu_pkg::CORDIC_STEPS
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [15:0] angle,
  output logic signed [31:0]      cos_q,
  output logic signed [31:0]      sin_q
);

  logic signed [33:0] x_q [STEPS];
  logic signed [33:0] y_q [STEPS];
  logic signed [33:0] z_q [STEPS];
  logic               neg_q [STEPS];

  logic signed [33:0] z_fold;
  logic               neg_fold;

  // fold into [-pi/2, pi/2]
  always_comb begin
    z_fold   = {{2{angle[15]}}, angle, 16'b0};
    neg_fold = 1'b0;
    if (z_fold > tccu_pkg::TURN_QUARTER) begin
      z_fold   = z_fold - tccu_pkg::TURN_HALF;
      neg_fold = 1'b1;
    end else if (z_fold < -tccu_pkg::TURN_QUARTER) begin
      z_fold   = z_fold + tccu_pkg::TURN_HALF;
      neg_fold = 1'b1;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [33:0] xp, yp, zp;
    logic               np;
    logic signed [33:0] at;
    if (i == 0) begin : g_first
      assign xp = tccu_pkg::INV_GAIN_Q30;
      assign yp = '0;
      assign zp = z_fold;
      assign np = neg_fold;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
      assign np = neg_q[i-1];
    end
    assign at = {2'b00, tccu_pkg::atan_turn(5'(i))};

    always_ff @(posedge clk) begin
      if (en) begin
        neg_q[i] <= np;
        if (zp >= 0) begin
          x_q[i] <= xp - (yp >>> i);
          y_q[i] <= yp + (xp >>> i);
          z_q[i] <= zp - at;
        end else begin
          x_q[i] <= xp + (yp >>> i);
          y_q[i] <= yp - (xp >>> i);
          z_q[i] <= zp + at;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_q[STEPS-1]) begin
        cos_q <= 32'(-x_q[STEPS-1]);
        sin_q <= 32'(-y_q[STEPS-1]);
      end else begin
        cos_q <= x_q[STEPS-1][31:0];
        sin_q <= y_q[STEPS-1][31:0];
      end
    end
  end

endmodule
`default_nettype wire

### sv/tilt_compensated_compass_heading_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// throughput: one sample per cycle while no result is stalled, set by the fully unrolled cordic stages
// the whole pipeline advances together and holds while a result is stalled
// reset: rst clears all valid bits, offsets to 0 and tilt compensation on
// ----------------------------------------------------------------------------
// tilt_compensated_compass_heading_unit
// hard-iron correction, cordic tilt compensation and atan2 heading
// ----------------------------------------------------------------------------
module tilt_compensated_compass_heading_unit #(
  parameter int unsigned STEPS = tccu_pkg::CORDIC_STEPS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] mag_x,
  input  wire logic signed [15:0] mag_y,
  input  wire logic signed [15:0] mag_z,
  input  wire logic signed [15:0] roll_angle,
  input  wire logic signed [15:0] pitch_angle,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [15:0]             heading_turn,
  output logic signed [15:0]      cal_x,
  output logic signed [15:0]      cal_y,
  output logic signed [15:0]      cal_z
);

  // stage map: 0 input, 1..STEPS+1 sincos, then two multiply stages,
  // sum, vector prep, STEPS vectoring steps, output rounding
  localparam int unsigned DEPTH  = 2 * STEPS + 7;
  localparam int unsigned ST_M1  = STEPS + 2;
  localparam int unsigned ST_V0  = STEPS + 5;

  // configuration registers
  logic signed [15:0] offset_x, offset_y, offset_z;
  logic               tilt_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x    <= '0;
      offset_y    <= '0;
      offset_z    <= '0;
      tilt_enable <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        tccu_pkg::REG_OFFSET_X:    offset_x    <= cfg_data;
        tccu_pkg::REG_OFFSET_Y:    offset_y    <= cfg_data;
        tccu_pkg::REG_OFFSET_Z:    offset_z    <= cfg_data;
        tccu_pkg::REG_TILT_ENABLE: tilt_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless the result is held
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic           vld   [DEPTH];
  tccu_pkg::cal_t cal_q [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < DEPTH; k++) vld[k] <= vld[k-1];
    end
  end

  // input stage: offset correction with saturation
  logic signed [15:0] roll_q, pitch_q;

  always_ff @(posedge clk) begin
    if (en) begin
      cal_q[0].x <= tccu_pkg::sub_sat16(mag_x, offset_x);
      cal_q[0].y <= tccu_pkg::sub_sat16(mag_y, offset_y);
      cal_q[0].z <= tccu_pkg::sub_sat16(mag_z, offset_z);
      roll_q     <= roll_angle;
      pitch_q    <= pitch_angle;
      for (int k = 1; k < DEPTH; k++) cal_q[k] <= cal_q[k-1];
    end
  end

  // sine and cosine of roll and pitch
  logic signed [31:0] cr, sr, cp, sp;

  tccu_sincos #(.STEPS(STEPS)) u_roll (
    .clk(clk), .en(en), .angle(roll_q), .cos_q(cr), .sin_q(sr)
  );

  tccu_sincos #(.STEPS(STEPS)) u_pitch (
    .clk(clk), .en(en), .angle(pitch_q), .cos_q(cp), .sin_q(sp)
  );

  // first multiply: cross terms back to Q30 (floor)
  logic signed [63:0] srsp_full, crsp_full;
  logic signed [31:0] srsp, crsp, cr1, sr1, cp1;

  assign srsp_full = 64'(sr) * 64'(sp);
  assign crsp_full = 64'(cr) * 64'(sp);

  always_ff @(posedge clk) begin
    if (en) begin
      srsp <= srsp_full[61:30];
      crsp <= crsp_full[61:30];
      cr1  <= cr;
      sr1  <= sr;
      cp1  <= cp;
    end
  end

  // second multiply: field times trig factors
  tccu_pkg::cal_t     c1;
  logic signed [47:0] p_xc, p_ys, p_zc, p_yc, p_zs;

  assign c1 = cal_q[ST_M1];

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc <= 48'(c1.x) * 48'(cp1);
      p_ys <= 48'(c1.y) * 48'(srsp);
      p_zc <= 48'(c1.z) * 48'(crsp);
      p_yc <= 48'(c1.y) * 48'(cr1);
      p_zs <= 48'(c1.z) * 48'(sr1);
    end
  end

  // horizontal components, or level mode with the raw axes
  tccu_pkg::cal_t     c2;
  logic signed [51:0] xh, yh;

  assign c2 = cal_q[ST_M1+1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (tilt_enable) begin
        xh <= 52'(p_xc) + 52'(p_ys) + 52'(p_zc);
        yh <= 52'(p_yc) - 52'(p_zs);
      end else begin
        xh <= {{6{c2.x[15]}}, c2.x, 30'b0};
        yh <= {{6{c2.y[15]}}, c2.y, 30'b0};
      end
    end
  end

  // vector prep: zero vector flag, left half-plane flip
  logic signed [51:0] vx_q [STEPS+1];
  logic signed [51:0] vy_q [STEPS+1];
  logic [31:0]        vz_q [STEPS+1];
  logic               zero_q [STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      zero_q[0] <= (xh == '0) && (yh == '0);
      if (xh < 0) begin
        vx_q[0] <= -xh;
        vy_q[0] <= -yh;
        vz_q[0] <= 32'h8000_0000;
      end else begin
        vx_q[0] <= xh;
        vy_q[0] <= yh;
        vz_q[0] <= '0;
      end
    end
  end

  // vectoring steps drive y toward zero
  for (genvar i = 0; i < STEPS; i++) begin : g_vec
    logic [31:0] at;
    assign at = tccu_pkg::atan_turn(5'(i));

    always_ff @(posedge clk) begin
      if (en) begin
        zero_q[i+1] <= zero_q[i];
        if (vy_q[i] >= 0) begin
          vx_q[i+1] <= vx_q[i] + (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] - (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] + at;
        end else begin
          vx_q[i+1] <= vx_q[i] - (vy_q[i] >>> i);
          vy_q[i+1] <= vy_q[i] + (vx_q[i] >>> i);
          vz_q[i+1] <= vz_q[i] - at;
        end
      end
    end
  end

  // output: round to 16-bit turn units, wraps at full turn
  logic [31:0] ang_rnd;
  assign ang_rnd = vz_q[STEPS] + 32'h0000_8000;

  always_ff @(posedge clk) begin
    if (en) begin
      heading_turn <= zero_q[STEPS] ? 16'd0 : ang_rnd[31:16];
    end
  end

  assign out_valid = vld[DEPTH-1];
  assign cal_x     = cal_q[DEPTH-1].x;
  assign cal_y     = cal_q[DEPTH-1].y;
  assign cal_z     = cal_q[DEPTH-1].z;

  // vector prep stage index documents the map above
  if (ST_V0 + STEPS + 2 != DEPTH) begin : g_bad_map
    $error("stage map mismatch");
  end

endmodule
`default_nettype wire

### sv/tccu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tccu_checker
// port-level checks of the compass heading unit
// ----------------------------------------------------------------------------
module tccu_port_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] heading_turn
);

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // input holds only because a result is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without held result");

  // a held result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("held result dropped");

  // a held heading keeps its value
  a_heading_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(heading_turn))
    else $error("held heading changed");

endmodule

bind tilt_compensated_compass_heading_unit tccu_port_props u_tccu_port_props (.*);
`default_nettype wire
